@@ rtl/max_tracking_stack_assert.svh @@
// Assertion macros for the stack RTL (included by mts_datapath).
`ifndef MAX_TRACKING_STACK_ASSERT_SVH
`define MAX_TRACKING_STACK_ASSERT_SVH

// Checked only outside reset.
`define MTS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define MTS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/mts_pkg.sv @@
`default_nettype none

package mts_pkg;

  localparam int STACK_DEPTH_DEFAULT = 64;
  localparam int DATA_WIDTH_DEFAULT  = 32;

  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load_top;
    logic load_out;
  } mts_ctrl_t;

  typedef struct packed {
    logic need_load;
  } mts_stat_t;

endpackage

`default_nettype wire

@@ rtl/mts_ctrl.sv @@
`default_nettype none

module mts_ctrl
  import mts_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      s_axis_tvalid,
  output logic           s_axis_tready,
  output logic           m_axis_tvalid,
  input  wire logic      m_axis_tready,
  output mts_ctrl_t      ctrl,
  input  wire mts_stat_t stat
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD,
    S_DONE
  } state_t;

  state_t state;
  logic   out_valid;

  assign s_axis_tready = (state == S_IDLE) && !rst;
  assign m_axis_tvalid = out_valid;

  assign ctrl.capture  = s_axis_tvalid && s_axis_tready;
  assign ctrl.exec     = (state == S_EXEC);
  assign ctrl.load_top = (state == S_LOAD);
  assign ctrl.load_out = (state == S_DONE) && (!out_valid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (ctrl.capture) state <= S_EXEC;
        end
        S_EXEC: begin
          state <= stat.need_load ? S_LOAD : S_DONE;
        end
        S_LOAD: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (ctrl.load_out) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (ctrl.load_out) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/mts_datapath.sv @@
`default_nettype none

`include "max_tracking_stack_assert.svh"

module mts_datapath
  import mts_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT,
  parameter int DATA_WIDTH  = DATA_WIDTH_DEFAULT,
  localparam int CW    = $clog2(STACK_DEPTH + 1),
  localparam int IN_W  = ((DATA_WIDTH + 7) / 8) * 8,
  localparam int OUT_B = 2 * DATA_WIDTH + CW + 1 + STATUS_W,
  localparam int OUT_W = ((OUT_B + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [IN_W-1:0]  s_axis_tdata,
  input  wire logic [CMD_W-1:0] s_axis_tuser,
  input  wire mts_ctrl_t        ctrl,
  output mts_stat_t             stat,
  output logic [OUT_W-1:0]      m_axis_tdata
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);
  localparam logic [CW-1:0] TWO_C   = CW'(2);

  // Each entry: {running max, value}.
  logic [2*DATA_WIDTH-1:0] mem [STACK_DEPTH];
  logic [2*DATA_WIDTH-1:0] rd_data;
  logic [2*DATA_WIDTH-1:0] wr_data;
  logic [AW-1:0]           rd_addr;
  logic                    wr_en;

  logic [CMD_W-1:0]      cap_cmd;
  logic [DATA_WIDTH-1:0] cap_val;
  logic [CW-1:0]         count;
  logic [DATA_WIDTH-1:0] top_val;
  logic [DATA_WIDTH-1:0] top_max;
  logic [STATUS_W-1:0]   status;

  logic [DATA_WIDTH-1:0] out_top;
  logic [DATA_WIDTH-1:0] out_max;
  logic [CW-1:0]         out_count;
  logic                  out_empty;
  logic [STATUS_W-1:0]   out_status;

  logic [DATA_WIDTH-1:0] new_max;
  logic                  is_push;
  logic                  is_pop;

  always_comb begin
    is_push = 1'b0;
    is_pop  = 1'b0;
    unique case (cap_cmd)
      CMD_PUSH: is_push = 1'b1;
      CMD_POP:  is_pop  = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    new_max = cap_val;
    if (count != '0 && $signed(top_max) > $signed(cap_val)) new_max = top_max;
  end

  assign wr_en   = ctrl.exec && is_push && (count < DEPTH_C);
  assign wr_data = {new_max, cap_val};
  assign rd_addr = AW'(count - TWO_C);

  assign stat.need_load = is_pop && (count >= TWO_C);

  always_ff @(posedge clk) begin
    if (wr_en) mem[count[AW-1:0]] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.exec) begin
      if (is_push && count < DEPTH_C) begin
        count <= count + ONE_C;
      end else if (is_pop && count != '0) begin
        count <= count - ONE_C;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cap_cmd <= s_axis_tuser;
      cap_val <= s_axis_tdata[DATA_WIDTH-1:0];
    end
    if (ctrl.exec) begin
      status <= ST_OK;
      if (is_push) begin
        if (count < DEPTH_C) begin
          top_val <= cap_val;
          top_max <= new_max;
        end else begin
          status <= ST_OVERFLOW;
        end
      end else if (is_pop && count == '0) begin
        status <= ST_UNDERFLOW;
      end
    end
    if (ctrl.load_top) begin
      top_max <= rd_data[2*DATA_WIDTH-1:DATA_WIDTH];
      top_val <= rd_data[DATA_WIDTH-1:0];
    end
    if (ctrl.load_out) begin
      out_count  <= count;
      out_empty  <= (count == '0);
      out_status <= status;
      out_top    <= (count == '0) ? '0 : top_val;
      out_max    <= (count == '0) ? '0 : top_max;
    end
  end

  assign m_axis_tdata = OUT_W'({out_status, out_empty, out_count, out_max, out_top});

  `MTS_ASSERT(a_count_bound, clk, rst, count <= DEPTH_C, "fill level beyond depth")
  `MTS_ASSERT(a_count_hold, clk, rst, !ctrl.exec |=> $stable(count), "fill level moved outside exec")
  `MTS_ASSERT(a_max_ge_top, clk, rst, count != '0 |-> $signed(top_max) >= $signed(top_val), "running max below top value")

endmodule

`default_nettype wire

@@ rtl/max_tracking_stack.sv @@
// Max-tracking LIFO stack, one command word in, one result word out.
// Each command runs through control states EXEC, then LOAD for a pop that refills
// the top from the entry memory (one registered read port), then DONE, where the
// registered result is loaded; a new command is taken only back in IDLE, after
// that load, and so can be taken while a result waits downstream.
// Reset (sync, active high) empties the stack; entry memory is not cleared.
`default_nettype none

module max_tracking_stack
  import mts_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT,
  parameter int DATA_WIDTH  = DATA_WIDTH_DEFAULT,
  localparam int CW    = $clog2(STACK_DEPTH + 1),
  localparam int IN_W  = ((DATA_WIDTH + 7) / 8) * 8,
  localparam int OUT_B = 2 * DATA_WIDTH + CW + 1 + STATUS_W,
  localparam int OUT_W = ((OUT_B + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [IN_W-1:0]  s_axis_tdata,  // push_value
  input  wire logic [CMD_W-1:0] s_axis_tuser,  // command
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [OUT_W-1:0]      m_axis_tdata   // top_value, max_value, entry_count,
                                               // is_empty, status
);

  mts_ctrl_t ctrl;
  mts_stat_t stat;

  mts_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .ctrl          (ctrl),
    .stat          (stat)
  );

  mts_datapath #(
    .STACK_DEPTH (STACK_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .ctrl         (ctrl),
    .stat         (stat),
    .m_axis_tdata (m_axis_tdata)
  );

endmodule

`default_nettype wire
